FILE: hdl/cycle_counter_time_interpolator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the cycle counter time interpolator
// Clocked, reset-gated property checks used by the RTL modules.
// ---------------------------------------------------------------------------
`ifndef CYCLE_COUNTER_TIME_INTERPOLATOR_ASSERT_SVH
`define CYCLE_COUNTER_TIME_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define CCTI_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CCTI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/ccti_pkg.sv
// ---------------------------------------------------------------------------
// ccti_pkg
// Shared constants and types of the cycle counter time interpolator.
// ---------------------------------------------------------------------------
package ccti_pkg;

    localparam int DATA_W         = 64;
    localparam int RATE_FRAC_BITS = 48;
    localparam int CFG_W          = 40;
    localparam int CFG_IDX_W      = 2;
    localparam int HALF_W         = DATA_W / 2;
    localparam int PROD_W         = 2 * DATA_W;
    localparam int MUL_STEPS      = 4;
    localparam int MUL_CNT_W      = 3;
    localparam int DIV_CNT_W      = $clog2(DATA_W);

    localparam logic [CFG_IDX_W-1:0] CFG_RELIABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESYNC    = 2'd2;

    localparam logic [CFG_W-1:0] CALIBRATE_RESET = 40'd2000000000;
    localparam logic [CFG_W-1:0] RESYNC_RESET    = 40'd20000000000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_DECIDE,
        ST_MUL,
        ST_DIV,
        ST_SUM,
        ST_CLAMP,
        ST_DONE
    } state_t;

endpackage

FILE: hdl/ccti_mul.sv
// ---------------------------------------------------------------------------
// ccti_mul
// Shared 64x64 multiplier: one 32x32 partial product per cycle, registered,
// then shifted into a 128-bit accumulator on the following cycle.
// ---------------------------------------------------------------------------
module ccti_mul (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [ccti_pkg::DATA_W-1:0]    a,
    input  logic [ccti_pkg::DATA_W-1:0]    b,
    output logic                           done,
    output logic [ccti_pkg::PROD_W-1:0]    product
);

    logic                                busy_reg;
    logic [ccti_pkg::MUL_CNT_W-1:0]      cnt_reg;
    logic [ccti_pkg::DATA_W-1:0]         pp_reg;
    logic [1:0]                          pp_sh_reg;
    logic                                pp_valid_reg;
    logic [ccti_pkg::PROD_W-1:0]         acc_reg;
    logic                                done_reg;

    logic [ccti_pkg::HALF_W-1:0]         a_half;
    logic [ccti_pkg::HALF_W-1:0]         b_half;
    logic [ccti_pkg::DATA_W-1:0]         pp_next;
    logic [1:0]                          pp_sh_next;
    logic [ccti_pkg::PROD_W-1:0]         acc_next;
    logic                                last_step;

    assign last_step = (cnt_reg == ccti_pkg::MUL_CNT_W'(ccti_pkg::MUL_STEPS));

    always_comb begin
        a_half     = cnt_reg[0] ? a[ccti_pkg::DATA_W-1:ccti_pkg::HALF_W]
                                : a[ccti_pkg::HALF_W-1:0];
        b_half     = cnt_reg[1] ? b[ccti_pkg::DATA_W-1:ccti_pkg::HALF_W]
                                : b[ccti_pkg::HALF_W-1:0];
        pp_next    = {{ccti_pkg::HALF_W{1'b0}}, a_half} * {{ccti_pkg::HALF_W{1'b0}}, b_half};
        pp_sh_next = {1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]};
        acc_next   = acc_reg + ({{ccti_pkg::DATA_W{1'b0}}, pp_reg} << {pp_sh_reg, 5'b0});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            cnt_reg      <= '0;
            pp_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg     <= 1'b1;
                cnt_reg      <= '0;
                pp_valid_reg <= 1'b0;
            end else if (busy_reg) begin
                pp_valid_reg <= !last_step;
                cnt_reg      <= cnt_reg + 1'b1;
                if (last_step) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (!last_step) begin
                pp_reg    <= pp_next;
                pp_sh_reg <= pp_sh_next;
            end
            if (pp_valid_reg) begin
                acc_reg <= acc_next;
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: hdl/ccti_div.sv
// ---------------------------------------------------------------------------
// ccti_div
// Restoring divider for the rate: floor(num * 2^RATE_FRAC_BITS / den),
// one quotient bit per cycle, saturated when the quotient overflows.
// ---------------------------------------------------------------------------
module ccti_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [ccti_pkg::DATA_W-1:0]    num,
    input  logic [ccti_pkg::DATA_W-1:0]    den,
    output logic                           done,
    output logic [ccti_pkg::DATA_W-1:0]    quot
);

    logic                                busy_reg;
    logic [ccti_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic [ccti_pkg::DATA_W-1:0]         rem_reg;
    logic [ccti_pkg::DATA_W-1:0]         lo_reg;
    logic [ccti_pkg::DATA_W-1:0]         q_reg;
    logic                                done_reg;

    logic [ccti_pkg::DATA_W-1:0]         num_hi;
    logic [ccti_pkg::DATA_W-1:0]         num_lo;
    logic                                overflow;
    logic [ccti_pkg::DATA_W:0]           rem_sh;
    logic                                take;
    logic [ccti_pkg::DATA_W-1:0]         rem_next;

    always_comb begin
        num_hi   = num >> (ccti_pkg::DATA_W - ccti_pkg::RATE_FRAC_BITS);
        num_lo   = num << ccti_pkg::RATE_FRAC_BITS;
        overflow = (num_hi >= den);
        rem_sh   = {rem_reg, lo_reg[ccti_pkg::DATA_W-1]};
        take     = rem_sh[ccti_pkg::DATA_W] ||
                   (rem_sh[ccti_pkg::DATA_W-1:0] >= den);
        rem_next = take ? (rem_sh[ccti_pkg::DATA_W-1:0] - den)
                        : rem_sh[ccti_pkg::DATA_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg  <= '0;
                busy_reg <= !overflow;
                done_reg <= overflow;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (&cnt_reg) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num_hi;
            lo_reg  <= num_lo;
            q_reg   <= overflow ? '1 : '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            lo_reg  <= lo_reg << 1;
            q_reg   <= {q_reg[ccti_pkg::DATA_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

    `include "cycle_counter_time_interpolator_assert.svh"

    `CCTI_ASSERT_NOW(a_div_no_restart, aclk, aresetn, busy_reg, !start, "divider restarted while busy")

endmodule

FILE: hdl/cycle_counter_time_interpolator.sv
// A pass-through, anchoring, uncalibrated or re-anchoring query goes through
// ST_DIST, ST_DECIDE and ST_DONE; an interpolated query adds ST_MUL
// (four partial products on the shared 32x32 multiplier plus accumulate), ST_SUM and ST_CLAMP.
// A calibrating query adds ST_DIV, where the divider yields one bit a cycle.
// Throughput: one query at a time; s_tready returns the cycle after the result loads.
// Reset (aresetn low, synchronous) clears the anchor and the rate and restores the registers to their reset values.
// ---------------------------------------------------------------------------
// cycle_counter_time_interpolator
// Sequencer that turns a cycle count and a reference time into a time in
// microseconds, monotonic when interpolated or re-anchored, using a shared multiplier and a serial divider.
// ---------------------------------------------------------------------------
module cycle_counter_time_interpolator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [ccti_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ccti_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [2*ccti_pkg::DATA_W-1:0]     s_tdata,  // cycle_count, wall_us
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ccti_pkg::DATA_W-1:0]       m_tdata   // time_us
);

    localparam int W = ccti_pkg::DATA_W;

    ccti_pkg::state_t state_reg, state_next;

    logic                          reliable_reg;
    logic [ccti_pkg::CFG_W-1:0]    calibrate_reg;
    logic [ccti_pkg::CFG_W-1:0]    resync_reg;

    logic [W-1:0] cyc_reg;
    logic [W-1:0] wall_reg;
    logic [W-1:0] dist_reg;
    logic [W-1:0] num_reg;
    logic         anchor_valid_reg;
    logic [W-1:0] anchor_cycles_reg;
    logic [W-1:0] anchor_us_reg;
    logic [W-1:0] rate_reg;
    logic [W-1:0] last_reg;
    logic [W-1:0] sum_reg;
    logic [W-1:0] res_reg;
    logic         m_valid_reg;
    logic [W-1:0] m_data_reg;

    logic         in_xfer;
    logic         out_free;
    logic         uncal;
    logic         over_cal;
    logic         over_resync;
    logic         mul_start;
    logic         div_start;
    logic         load_out;
    logic         mul_done;
    logic         div_done;
    logic [ccti_pkg::PROD_W-1:0] product;
    logic [W-1:0] quot;
    logic [W-1:0] offset;
    logic [W:0]   sum_full;
    logic [W-1:0] clamp_in;
    logic [W-1:0] clamp_out;

    assign in_xfer     = s_tvalid && s_tready;
    assign out_free    = !m_valid_reg || m_tready;
    assign uncal       = (rate_reg == '0);
    assign over_cal    = (dist_reg > {{(W-ccti_pkg::CFG_W){1'b0}}, calibrate_reg});
    assign over_resync = (dist_reg > {{(W-ccti_pkg::CFG_W){1'b0}}, resync_reg});

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ccti_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = ccti_pkg::ST_DIST;
            end
            ccti_pkg::ST_DIST: begin
                state_next = ccti_pkg::ST_DECIDE;
            end
            ccti_pkg::ST_DECIDE: begin
                if (!reliable_reg || !anchor_valid_reg) begin
                    state_next = ccti_pkg::ST_DONE;
                end else if (uncal) begin
                    state_next = over_cal ? ccti_pkg::ST_DIV : ccti_pkg::ST_DONE;
                end else begin
                    state_next = over_resync ? ccti_pkg::ST_DONE : ccti_pkg::ST_MUL;
                end
            end
            ccti_pkg::ST_MUL: begin
                if (mul_done) state_next = ccti_pkg::ST_SUM;
            end
            ccti_pkg::ST_DIV: begin
                if (div_done) state_next = ccti_pkg::ST_DONE;
            end
            ccti_pkg::ST_SUM: begin
                state_next = ccti_pkg::ST_CLAMP;
            end
            ccti_pkg::ST_CLAMP: begin
                state_next = ccti_pkg::ST_DONE;
            end
            ccti_pkg::ST_DONE: begin
                if (out_free) state_next = ccti_pkg::ST_IDLE;
            end
            default: begin
                state_next = ccti_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready  = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        clamp_in  = wall_reg;
        case (state_reg)
            ccti_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            ccti_pkg::ST_DECIDE: begin
                mul_start = reliable_reg && anchor_valid_reg && !uncal && !over_resync;
                div_start = reliable_reg && anchor_valid_reg && uncal && over_cal;
            end
            ccti_pkg::ST_CLAMP: begin
                clamp_in = sum_reg;
            end
            ccti_pkg::ST_DONE: begin
                load_out = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        offset    = (|product[ccti_pkg::PROD_W-1:ccti_pkg::RATE_FRAC_BITS+W])
                    ? '1 : product[ccti_pkg::RATE_FRAC_BITS+W-1:ccti_pkg::RATE_FRAC_BITS];
        sum_full  = {1'b0, anchor_us_reg} + {1'b0, offset};
        clamp_out = (last_reg > clamp_in) ? last_reg : clamp_in;
    end

    ccti_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (dist_reg),
        .b       (rate_reg),
        .done    (mul_done),
        .product (product)
    );

    ccti_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_reg),
        .den     (dist_reg),
        .done    (div_done),
        .quot    (quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ccti_pkg::ST_IDLE;
            reliable_reg      <= 1'b1;
            calibrate_reg     <= ccti_pkg::CALIBRATE_RESET;
            resync_reg        <= ccti_pkg::RESYNC_RESET;
            anchor_valid_reg  <= 1'b0;
            anchor_cycles_reg <= '0;
            anchor_us_reg     <= '0;
            rate_reg          <= '0;
            last_reg          <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                case (cfg_index)
                    ccti_pkg::CFG_RELIABLE:  reliable_reg  <= cfg_data[0];
                    ccti_pkg::CFG_CALIBRATE: calibrate_reg <= cfg_data;
                    ccti_pkg::CFG_RESYNC:    resync_reg    <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == ccti_pkg::ST_DECIDE && reliable_reg) begin
                if (!anchor_valid_reg) begin
                    anchor_valid_reg  <= 1'b1;
                    anchor_cycles_reg <= cyc_reg;
                    anchor_us_reg     <= wall_reg;
                end else if (!uncal && over_resync) begin
                    anchor_cycles_reg <= cyc_reg;
                    anchor_us_reg     <= clamp_out;
                    last_reg          <= clamp_out;
                end
            end

            if (state_reg == ccti_pkg::ST_DIV && div_done) begin
                rate_reg <= quot;
            end

            if (state_reg == ccti_pkg::ST_CLAMP) begin
                last_reg <= clamp_out;
            end

            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            cyc_reg  <= s_tdata[W-1:0];
            wall_reg <= s_tdata[2*W-1:W];
        end
        if (state_reg == ccti_pkg::ST_DIST) begin
            dist_reg <= cyc_reg - anchor_cycles_reg;
            num_reg  <= wall_reg - anchor_us_reg;
        end
        if (state_reg == ccti_pkg::ST_DECIDE) begin
            if (reliable_reg && anchor_valid_reg && !uncal && over_resync) begin
                res_reg <= clamp_out;
            end else begin
                res_reg <= wall_reg;
            end
        end
        if (state_reg == ccti_pkg::ST_SUM) begin
            sum_reg <= sum_full[W] ? '1 : sum_full[W-1:0];
        end
        if (state_reg == ccti_pkg::ST_CLAMP) begin
            res_reg <= clamp_out;
        end
        if (load_out) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `include "cycle_counter_time_interpolator_assert.svh"

    `CCTI_ASSERT_NOW(a_last_monotonic, aclk, aresetn, $past(aresetn), last_reg >= $past(last_reg), "last returned time decreased")
    `CCTI_ASSERT_NOW(a_rate_needs_anchor, aclk, aresetn, rate_reg != '0, anchor_valid_reg, "rate set without an anchor")
    `CCTI_ASSERT_NEXT(a_result_loaded, aclk, aresetn, load_out, m_tvalid && (m_tdata == $past(res_reg)), "result not presented after load")
    `CCTI_ASSERT_NOW(a_single_unit, aclk, aresetn, mul_start || div_start, !(mul_start && div_start) && (state_reg == ccti_pkg::ST_DECIDE), "arithmetic unit started out of sequence")

endmodule

FILE: test/cycle_counter_time_interpolator_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cycle_counter_time_interpolator_tb
// Self-checking bench for the time interpolator. A cycle-accurate-free
// predictor tracks anchor, rate, clamp and registers and computes every
// returned time. The bench first covers anchoring, thresholds, wrapped
// distances, pass-through and calibration, then drives a plausible clock
// timeline with jitter, backward steps and counter jumps under several
// register settings. The sender idles in bursts and the receiver stalls.
// ---------------------------------------------------------------------------
module cycle_counter_time_interpolator_tb;

    localparam int DATA_W         = ccti_pkg::DATA_W;
    localparam int PROD_W         = ccti_pkg::PROD_W;
    localparam int CFG_W          = ccti_pkg::CFG_W;
    localparam int CFG_IDX_W      = ccti_pkg::CFG_IDX_W;
    localparam int RATE_FRAC_BITS = ccti_pkg::RATE_FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_RELIABLE  = ccti_pkg::CFG_RELIABLE;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATE = ccti_pkg::CFG_CALIBRATE;
    localparam logic [CFG_IDX_W-1:0] CFG_RESYNC    = ccti_pkg::CFG_RESYNC;

    localparam logic [CFG_W-1:0] CALIBRATE_RESET = ccti_pkg::CALIBRATE_RESET;
    localparam logic [CFG_W-1:0] RESYNC_RESET    = ccti_pkg::RESYNC_RESET;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam logic [CFG_W-1:0] CFG_MAX = '1;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_RARELY,
        READY_NEVER
    } flow_t;

    class time_checker;
        bit                  reliable;
        bit [CFG_W-1:0]      calibrate_cycles;
        bit [CFG_W-1:0]      resync_cycles;
        bit                  anchored;
        bit [DATA_W-1:0]     anchor_cyc;
        bit [DATA_W-1:0]     anchor_us;
        bit [DATA_W-1:0]     rate;
        bit [DATA_W-1:0]     last_us;
        bit [DATA_W-1:0]     expected_us[$];
        int                  mismatches;

        function new();
            reliable         = 1'b1;
            calibrate_cycles = CALIBRATE_RESET;
            resync_cycles    = RESYNC_RESET;
            anchored         = 1'b0;
            anchor_cyc       = '0;
            anchor_us        = '0;
            rate             = '0;
            last_us          = '0;
            mismatches       = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_RELIABLE:  reliable = value[0];
                CFG_CALIBRATE: calibrate_cycles = value;
                CFG_RESYNC:    resync_cycles = value;
                default: ;
            endcase
        endfunction

        function bit [DATA_W-1:0] hold_monotonic(bit [DATA_W-1:0] t);
            if (last_us > t)
                return last_us;
            last_us = t;
            return t;
        endfunction

        function bit [DATA_W-1:0] interpolate(bit [DATA_W-1:0] cyc, bit [DATA_W-1:0] wall);
            bit [DATA_W-1:0] dist_cyc;
            bit [DATA_W-1:0] offset;
            bit [DATA_W-1:0] t;
            bit [PROD_W-1:0] wide;
            bit [DATA_W:0]   sum;
            if (!reliable)
                return wall;
            if (!anchored || rate == '0) begin
                if (!anchored) begin
                    anchored   = 1'b1;
                    anchor_cyc = cyc;
                    anchor_us  = wall;
                end else begin
                    dist_cyc = cyc - anchor_cyc;
                    if (dist_cyc > {24'b0, calibrate_cycles}) begin
                        wide = {64'b0, wall - anchor_us} << RATE_FRAC_BITS;
                        wide = wide / {64'b0, dist_cyc};
                        rate = (wide[PROD_W-1:DATA_W] != '0) ? '1 : wide[DATA_W-1:0];
                    end
                end
                return wall;
            end
            dist_cyc = cyc - anchor_cyc;
            if (dist_cyc > {24'b0, resync_cycles}) begin
                anchor_cyc = cyc;
                t = hold_monotonic(wall);
                anchor_us = t;
                return t;
            end
            wide   = ({64'b0, dist_cyc} * {64'b0, rate}) >> RATE_FRAC_BITS;
            offset = (wide[PROD_W-1:DATA_W] != '0) ? '1 : wide[DATA_W-1:0];
            sum    = {1'b0, anchor_us} + {1'b0, offset};
            t      = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
            return hold_monotonic(t);
        endfunction

        function void note_query(bit [DATA_W-1:0] cyc, bit [DATA_W-1:0] wall);
            expected_us.push_back(interpolate(cyc, wall));
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_time(logic [DATA_W-1:0] got_us);
            bit [DATA_W-1:0] want_us;
            if (expected_us.size() == 0) begin
                report_mismatch($sformatf("time_us %h with no query pending", got_us));
            end else begin
                want_us = expected_us.pop_front();
                if (got_us !== want_us)
                    report_mismatch($sformatf("time_us %h, expected %h", got_us, want_us));
            end
        endtask
    endclass

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data  = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [2*DATA_W-1:0]     s_tdata   = '0;  // cycle_count, wall_us
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [DATA_W-1:0]       m_tdata;         // time_us

    time_checker             sb;
    int                      burst_left = 0;
    int                      stall_left = 0;
    flow_t                   stall_mode = READY_ALWAYS;
    int                      cycles     = 0;
    logic [DATA_W-1:0]       true_cyc;
    logic [DATA_W-1:0]       true_us;

    cycle_counter_time_interpolator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [DATA_W-1:0] rand_upto(logic [DATA_W-1:0] hi);
        logic [DATA_W-1:0] r;
        r = rand64() >> $urandom_range(0, 63);
        if (hi == '1)
            return r;
        return r % (hi + 64'd1);
    endfunction

    // keep each wall-clock advance below 2^48 us so the timeline never wraps
    function automatic logic [DATA_W-1:0] step_limit(bit long_span);
        logic [PROD_W-1:0] cap;
        logic [DATA_W-1:0] span;
        cap = (128'd1 << 96) / ({64'b0, sb.rate} + 128'd1);
        if (cap > 128'h100_0000_0000)
            cap = 128'h100_0000_0000;
        span = long_span ? {24'b0, sb.resync_cycles} * 2 + 2
                         : {24'b0, sb.resync_cycles} / 3 + 2;
        return (span < cap[DATA_W-1:0]) ? span : cap[DATA_W-1:0];
    endfunction

    function automatic void advance(logic [DATA_W-1:0] step);
        logic [PROD_W-1:0] gain;
        gain     = ({64'b0, step} * {64'b0, sb.rate}) >> RATE_FRAC_BITS;
        true_cyc = true_cyc + step;
        true_us  = true_us + gain[DATA_W-1:0] + 64'($urandom_range(0, 6)) - 64'd3;
    endfunction

    task automatic send_query(logic [DATA_W-1:0] cyc, logic [DATA_W-1:0] wall);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {wall, cyc};
        do @(posedge aclk); while (!s_tready);
        sb.note_query(cyc, wall);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.expected_us.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic random_query();
        logic [DATA_W-1:0] step;
        case ($urandom_range(0, 19))
            14: begin
                // land on the re-anchor threshold or one past it
                step = sb.anchor_cyc + {24'b0, sb.resync_cycles}
                       + 64'($urandom_range(0, 1)) - true_cyc;
                if (step > step_limit(1'b1))
                    step = rand_upto(step_limit(1'b0));
                advance(step);
                send_query(true_cyc, true_us);
            end
            15, 16: begin
                advance(rand_upto(step_limit(1'b0)));
                send_query(true_cyc, true_us - rand_upto(64'hFF_FFFF));
            end
            17: begin
                true_cyc = rand64();
                send_query(true_cyc, true_us);
            end
            18: send_query(true_cyc, true_us);
            19: begin
                advance(rand_upto(step_limit(1'b1)));
                send_query(true_cyc, true_us);
            end
            default: begin
                advance(rand_upto(step_limit(1'b0)));
                send_query(true_cyc, true_us);
            end
        endcase
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("cycle_counter_time_interpolator regression: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= flow_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(4, 60);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
            READY_RARELY: m_tready <= ($urandom_range(0, 3) == 0);
            default:      m_tready <= 1'b0;
        endcase
        if (aresetn && m_tvalid && m_tready)
            sb.check_time(m_tdata);
    end

    initial begin
        logic [DATA_W-1:0] c0;
        logic [DATA_W-1:0] w0;
        logic [DATA_W-1:0] dist_cyc;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] rate_t;
        logic [PROD_W-1:0] prod;
        logic [CFG_W-1:0]  resync;
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // uncalibrated: anchor, threshold, zero rate, wrapped distance
        c0 = rand64();
        w0 = (rand64() >> 16) | 64'h100_0000_0000;
        send_query(c0, w0);
        send_query(c0 + {24'b0, CALIBRATE_RESET}, w0 + 64'd5);
        send_query(c0 + {24'b0, CALIBRATE_RESET} + 64'd1, w0);
        send_query(c0 - 64'd1, w0 + 64'd1000);

        // pass-through
        wait_idle();
        write_reg(CFG_RELIABLE, '0);
        send_query('1, '1);
        send_query('0, '0);
        send_query({16{4'hA}}, {16{4'h5}});
        send_query({16{4'h5}}, {16{4'hA}});
        send_query(rand64(), rand64());
        send_query(rand64(), rand64());

        // calibration threshold extremes
        wait_idle();
        write_reg(CFG_RELIABLE, 40'd1);
        write_reg(CFG_CALIBRATE, CFG_MAX);
        send_query(c0 + {24'b0, CFG_MAX}, w0 + 64'd77);
        send_query(c0 + {24'b0, CFG_MAX} + 64'd1, w0);
        wait_idle();
        write_reg(CFG_CALIBRATE, '0);
        send_query(c0, w0 + 64'd3);
        send_query(c0 + 64'd1, w0);

        // calibrate once, occasionally to a saturated rate
        wait_idle();
        write_reg(CFG_CALIBRATE, 40'h2000_0000 | 40'($urandom_range(0, 32'h1FFF_FFFF)));
        write_reg(CFG_RESYNC, RESYNC_RESET);
        dist_cyc = 64'h4000_0000 + 64'($urandom_range(0, 32'hF_FFFF));
        if ($urandom_range(0, 7) == 0) begin
            num = dist_cyc << 17;
        end else begin
            rate_t = (rand64() >> $urandom_range(4, 40)) | 64'h100_0000;
            prod   = ({64'b0, dist_cyc} * {64'b0, rate_t}) >> RATE_FRAC_BITS;
            num    = prod[DATA_W-1:0];
        end
        true_cyc = c0 + dist_cyc;
        true_us  = w0 + num;
        send_query(true_cyc, true_us);
        advance(64'd1000);
        send_query(true_cyc, true_us);
        send_query(true_cyc, true_us - 64'd50);

        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            write_reg(CFG_CALIBRATE, rand_upto({24'b0, CFG_MAX}));
            case (phase)
                0:       resync = RESYNC_RESET;
                1:       resync = CFG_MAX;
                2:       resync = '0;
                3:       resync = 40'd1000;
                default: resync = rand_upto({24'b0, CFG_MAX});
            endcase
            write_reg(CFG_RESYNC, resync);
            if (phase == 3) begin
                write_reg(CFG_RELIABLE, '0);
                repeat (60) send_query(rand64(), rand64());
                wait_idle();
                write_reg(CFG_RELIABLE, 40'd1);
            end
            repeat (165) random_query();
        end

        // sum saturation and clamp at the top of the range
        wait_idle();
        write_reg(CFG_RESYNC, CFG_MAX);
        true_cyc = true_cyc + 64'h100_0000_0000;
        send_query(true_cyc, 64'hFFFF_FFFF_FFFF_FFF0);
        send_query(true_cyc + {24'b0, CFG_MAX}, '0);
        send_query(true_cyc, '0);
        send_query(true_cyc + 64'h200_0000_0000, '0);

        wait_idle();
        if (sb.mismatches == 0) begin
            $display("cycle_counter_time_interpolator regression: pass");
        end else begin
            $display("cycle_counter_time_interpolator regression: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/ccti_pkg.sv
hdl/ccti_mul.sv
hdl/ccti_div.sv
hdl/cycle_counter_time_interpolator.sv
test/cycle_counter_time_interpolator_tb.sv
